// ===== rtl/i2rd_pkg.sv =====
// Shared types, constants and the digit-to-ASCII lookup for the radix digit converter.
// No dependencies; every other file uses this package.
package i2rd_pkg;

	localparam int unsigned VALUE_BITS_DEF = 31;
	localparam int unsigned RADIX_W        = 6;
	localparam int unsigned CHAR_W         = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA  = 7'h37; // 'A' minus ten

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FETCH,
		ST_SHOW
	} i2rd_state_t;

	typedef struct packed {
		logic load;
		logic again;
	} div_cmd_t;

	typedef struct packed {
		logic               done;
		logic               quot_nz;
		logic [RADIX_W-1:0] rem;
	} div_stat_t;

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {1'b0, d};
		if (d < 6'd10)
			return CHAR_ZERO + dx;
		else
			return CHAR_ALPHA + dx;
	endfunction

endpackage

// ===== rtl/i2rd_value_if.sv =====
// Input channel carrying one integer per beat.
// Depends on i2rd_pkg for the default width.
interface i2rd_value_if #(
	parameter int unsigned VALUE_BITS = i2rd_pkg::VALUE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

// ===== rtl/i2rd_digit_if.sv =====
// Output channel carrying one ASCII digit and its end-of-number flag per beat.
// Depends on i2rd_pkg for the character width.
interface i2rd_digit_if;
	import i2rd_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] digit_char;
	logic              last_digit;

	modport source(output valid, output digit_char, output last_digit, input ready);
	modport sink(input valid, input digit_char, input last_digit, output ready);
endinterface

// ===== rtl/i2rd_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, keeps the quotient
// for the next division. Depends on i2rd_pkg.
module i2rd_div #(
	parameter int unsigned VALUE_BITS = i2rd_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  i2rd_pkg::div_cmd_t          cmd,
	input  logic [VALUE_BITS-1:0]       dividend,
	input  logic [i2rd_pkg::RADIX_W-1:0] radix,
	output i2rd_pkg::div_stat_t         stat
);
	import i2rd_pkg::*;

	localparam int unsigned BIT_W = $clog2(VALUE_BITS);
	localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(VALUE_BITS - 1);

	logic [VALUE_BITS-1:0] n_q;
	logic [RADIX_W-1:0]    rem_q;
	logic [BIT_W-1:0]      bit_q;
	logic                  busy_q;
	logic                  done_q;
	logic                  nz_q;

	logic [RADIX_W:0] shifted;
	logic [RADIX_W:0] diff;
	logic             ge;

	always_comb begin
		shifted = {rem_q, n_q[VALUE_BITS-1]};
		ge      = shifted >= {1'b0, radix};
		diff    = shifted - {1'b0, radix};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.load || cmd.again) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
			end else if (busy_q) begin
				bit_q <= bit_q + 1'b1;
				if (bit_q == LAST_BIT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load || cmd.again) begin
			rem_q <= '0;
			nz_q  <= 1'b0;
			if (cmd.load)
				n_q <= dividend;
		end else if (busy_q) begin
			// shift the next dividend bit in, subtract when it fits
			rem_q <= ge ? diff[RADIX_W-1:0] : shifted[RADIX_W-1:0];
			n_q   <= {n_q[VALUE_BITS-2:0], ge};
			nz_q  <= nz_q | ge;
		end
	end

	assign stat.done    = done_q;
	assign stat.quot_nz = nz_q;
	assign stat.rem     = rem_q;

endmodule

// ===== rtl/integer_to_radix_digits.sv =====
// Converts a positive integer to its ASCII digits in a programmable base (2..36),
// most significant digit first, flagging the last. Uses i2rd_pkg, i2rd_div and
// the two channel interfaces.
//
// A number is taken only while the block is idle. Each digit costs one pass of the
// bit-serial divider, and the digits are then popped from a digit stack, each one
// fetched and then held on the digit channel until the sink takes it; zero
// produces no beats. The radix register is clamped to 2..36 on write and must
// only be written while idle.
module integer_to_radix_digits #(
	parameter int unsigned VALUE_BITS = i2rd_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [i2rd_pkg::RADIX_W-1:0]  cfg_wdata,
	i2rd_value_if.sink                    number,
	i2rd_digit_if.source                  digits
);
	import i2rd_pkg::*;

	localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);
	localparam int unsigned IDX_W = $clog2(VALUE_BITS);

	i2rd_state_t state_q, state_d;

	logic [RADIX_W-1:0] radix_q;
	logic [CNT_W-1:0]   count_q;
	logic [CHAR_W-1:0]  rd_q;
	logic [CHAR_W-1:0]  stack_mem [VALUE_BITS];

	div_cmd_t  cmd;
	div_stat_t stat;
	logic      push;
	logic      pop;
	logic      clear;

	logic [CNT_W-1:0] count_dec;
	assign count_dec = count_q - 1'b1;

	i2rd_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.dividend (number.value),
		.radix    (radix_q),
		.stat     (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			if (cfg_wdata < RADIX_MIN)
				radix_q <= RADIX_MIN;
			else if (cfg_wdata > RADIX_MAX)
				radix_q <= RADIX_MAX;
			else
				radix_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (clear)
				count_q <= '0;
			else if (push)
				count_q <= count_q + 1'b1;
			else if (pop)
				count_q <= count_dec;
		end
	end

	// digit stack: remainders come out least significant first
	always_ff @(posedge clk) begin
		if (push)
			stack_mem[count_q[IDX_W-1:0]] <= digit_to_char(stat.rem);
		if (pop)
			rd_q <= stack_mem[count_dec[IDX_W-1:0]];
	end

	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.again    = 1'b0;
		push         = 1'b0;
		pop          = 1'b0;
		clear        = 1'b0;
		number.ready = 1'b0;
		digits.valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				number.ready = 1'b1;
				if (number.valid && (number.value != '0)) begin
					cmd.load = 1'b1;
					clear    = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				if (stat.done) begin
					push = 1'b1;
					if (stat.quot_nz)
						cmd.again = 1'b1;
					else
						state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				pop     = 1'b1;
				state_d = ST_SHOW;
			end
			ST_SHOW: begin
				digits.valid = 1'b1;
				if (digits.ready)
					state_d = (count_q == '0) ? ST_IDLE : ST_FETCH;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign digits.digit_char = rd_q;
	assign digits.last_digit = (count_q == '0);

endmodule

// ===== verif/integer_to_radix_digits_check.sv =====
// Digit-stream checker for integer_to_radix_digits: tracks the radix register, predicts the
// ASCII digits of every accepted number and compares each digit beat against them.
// Depends on i2rd_pkg and the two channel interfaces.
module integer_to_radix_digits_check #(
	parameter int unsigned VALUE_BITS = i2rd_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [i2rd_pkg::RADIX_W-1:0] cfg_wdata,
	i2rd_value_if                        number,
	i2rd_digit_if                        digits,
	output int                           fail_count,
	output int                           pending_digits
);
	timeunit 1ns;
	timeprecision 1ps;

	import i2rd_pkg::*;

	localparam int unsigned ASCII_ZERO    = 48;
	localparam int unsigned ASCII_UPPER_A = 65;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last_digit;
	} digit_beat_t;

	digit_beat_t        expected_digits[$];
	logic [RADIX_W-1:0] radix_q;

	// Divide repeatedly, then queue the digits most significant first.
	function automatic void predict_digits(input logic [VALUE_BITS-1:0] v,
			input logic [RADIX_W-1:0] base);
		longint unsigned   n;
		int unsigned       r;
		logic [CHAR_W-1:0] lsd_first[$];
		digit_beat_t       beat;
		n = longint'(v);
		while (n != 0) begin
			r = int'(n % base);
			if (r < 10)
				lsd_first.push_back(CHAR_W'(ASCII_ZERO + r));
			else
				lsd_first.push_back(CHAR_W'(ASCII_UPPER_A + r - 10));
			n = n / base;
		end
		while (lsd_first.size() != 0) begin
			beat.digit_char = lsd_first.pop_back();
			beat.last_digit = (lsd_first.size() == 0);
			expected_digits.push_back(beat);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : digit_scoreboard
		digit_beat_t want;
		int          errs;
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
			expected_digits.delete();
			fail_count <= 0;
			pending_digits <= 0;
		end else begin
			errs = 0;
			if (cfg_we) begin
				if (cfg_wdata < RADIX_MIN)
					radix_q <= RADIX_MIN;
				else if (cfg_wdata > RADIX_MAX)
					radix_q <= RADIX_MAX;
				else
					radix_q <= cfg_wdata;
			end
			// retire the oldest expectation before queuing a new number
			if (digits.valid && digits.ready) begin
				if (expected_digits.size() == 0) begin
					$error("digit_char: expected no beat, actual %0d", digits.digit_char);
					errs++;
				end else begin
					want = expected_digits.pop_front();
					if (digits.digit_char !== want.digit_char) begin
						$error("digit_char: expected %0d, actual %0d",
							want.digit_char, digits.digit_char);
						errs++;
					end
					if (digits.last_digit !== want.last_digit) begin
						$error("last_digit: expected %0d, actual %0d",
							want.last_digit, digits.last_digit);
						errs++;
					end
				end
			end
			if (number.valid && number.ready)
				predict_digits(number.value, radix_q);
			fail_count <= fail_count + errs;
			pending_digits <= expected_digits.size();
		end
	end

endmodule

// ===== verif/integer_to_radix_digits_test.sv =====
// Top-level testbench for integer_to_radix_digits: drives numbers and radix writes, stalls the
// digit channel at random and gives the verdict. Depends on i2rd_pkg, the channel interfaces,
// the block and integer_to_radix_digits_check.
module integer_to_radix_digits_test;
	timeunit 1ns;
	timeprecision 1ps;

	import i2rd_pkg::*;

	localparam int unsigned VB        = VALUE_BITS_DEF;
	localparam int unsigned SETTLE    = 2 * (VB + 3) + 8;
	localparam int unsigned IDLE_MAX  = 12;
	localparam int unsigned LIMIT     = 8 * (VB + 3) * VB;
	localparam int unsigned PER_PHASE = 43;
	localparam longint unsigned VALUE_TOP = (longint'(1) << VB) - 1;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [RADIX_W-1:0] cfg_wdata;
	int                 fail_count;
	int                 pending_digits;
	int unsigned        cur_base;
	bit                 quiet_source;
	bit                 quiet_sink;

	i2rd_value_if #(.VALUE_BITS(VB)) number_ch();
	i2rd_digit_if                    digit_ch();

	integer_to_radix_digits #(.VALUE_BITS(VB)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.number    (number_ch),
		.digits    (digit_ch)
	);

	integer_to_radix_digits_check #(.VALUE_BITS(VB)) i_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.number         (number_ch),
		.digits         (digit_ch),
		.fail_count     (fail_count),
		.pending_digits (pending_digits)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned draw_gap(input bit quiet);
		if (quiet)
			return 0;
		return $urandom_range(0, IDLE_MAX);
	endfunction

	// Mix of zero, extremes, powers of the base around their edges and values of random length.
	function automatic logic [VB-1:0] draw_value(input int unsigned base);
		int unsigned     kind;
		int unsigned     w;
		longint unsigned p;
		kind = $urandom_range(0, 15);
		case (kind)
			0: return '0;
			1: return VB'(VALUE_TOP);
			2: return VB'(1);
			3, 4: begin
				p = 1;
				w = $urandom_range(1, VB);
				while (w != 0 && p * base <= VALUE_TOP) begin
					p = p * base;
					w--;
				end
				return VB'(p - $urandom_range(0, 1));
			end
			default: begin
				w = $urandom_range(1, VB);
				return VB'({$urandom, $urandom}) & VB'(VALUE_TOP >> (VB - w));
			end
		endcase
	endfunction

	// Called and left at a falling edge; hold the beat until it is taken.
	task automatic send_number(input logic [VB-1:0] v);
		int unsigned gap;
		gap = draw_gap(quiet_source);
		if (gap != 0) begin
			number_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		number_ch.valid = 1'b1;
		number_ch.value = v;
		do
			@(posedge clk);
		while (!(number_ch.valid && number_ch.ready));
		@(negedge clk);
	endtask

	// Write the radix only once the block has drained.
	task automatic write_radix(input logic [RADIX_W-1:0] w);
		number_ch.valid = 1'b0;
		while (pending_digits != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_wdata = w;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		cur_base = 32'((w < RADIX_MIN) ? RADIX_MIN : ((w > RADIX_MAX) ? RADIX_MAX : w));
	endtask

	initial begin : digit_sink
		int unsigned stall;
		digit_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_gap(quiet_sink);
			if (stall != 0) begin
				digit_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			digit_ch.ready = 1'b1;
			do
				@(posedge clk);
			while (!(digit_ch.valid && digit_ch.ready));
			@(negedge clk);
		end
	end

	initial begin : watchdog
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < LIMIT) begin
			@(posedge clk);
			if ((number_ch.valid && number_ch.ready) || (digit_ch.valid && digit_ch.ready)
					|| cfg_we || arst_n !== 1'b1)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		logic [RADIX_W-1:0] radix_plan[10];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		number_ch.valid = 1'b0;
		number_ch.value = '0;
		quiet_source = 1'b0;
		quiet_sink = 1'b0;
		cur_base = 32'(RADIX_RESET);
		radix_plan = '{6'd16, 6'd3, 6'd37, 6'd1, 6'd7, 6'd36, 6'd2, 6'd10, 6'd0, 6'd0};
		radix_plan[8] = RADIX_W'($urandom_range(0, 63));
		radix_plan[9] = RADIX_W'($urandom_range(0, 63));
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// reset radix: single digit, carry into two digits, zero, widest value
		send_number(VB'(1));
		send_number(VB'(9));
		send_number(VB'(10));
		send_number('0);
		send_number(VB'(VALUE_TOP));
		// write below the range: clamps to binary
		write_radix('0);
		send_number(VB'(1));
		send_number(VB'(2));
		send_number(VB'(VALUE_TOP));
		send_number(VB'(VALUE_TOP >> 1) + VB'(1));
		// all-ones write: clamps to base 36, every letter reachable
		write_radix('1);
		send_number(VB'(35));
		send_number(VB'(36));
		send_number(VB'(1295));
		send_number(VB'(VALUE_TOP));
		send_number('0);
		write_radix(RADIX_MAX + 6'd1);
		send_number(VB'(46655));
		write_radix(RADIX_MIN - 6'd1);
		send_number(VB'(3));

		foreach (radix_plan[ph]) begin
			write_radix(radix_plan[ph]);
			quiet_source = ($urandom_range(0, 3) == 0);
			quiet_sink = ($urandom_range(0, 3) == 0);
			repeat (PER_PHASE) send_number(draw_value(cur_base));
		end
		number_ch.valid = 1'b0;
		quiet_sink = 1'b0;

		while (pending_digits != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== integer_to_radix_digits.f =====
rtl/i2rd_pkg.sv
rtl/i2rd_value_if.sv
rtl/i2rd_digit_if.sv
rtl/i2rd_div.sv
rtl/integer_to_radix_digits.sv
verif/integer_to_radix_digits_check.sv
verif/integer_to_radix_digits_test.sv
